[rtl/gbpf_pkg.sv]
// Shared types and constants of the Goldbach prime pair finder.
// No dependencies; used by gbpf_sieve_map and goldbach_prime_pair_finder.
package gbpf_pkg;

   localparam int NUM_W   = 8;
   localparam int COUNT_W = 6;

   localparam logic [NUM_W-1:0]   MIN_NUMBER = 8'd4;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 6'd63;

   typedef enum logic [3:0] {
      SCAN_IDLE  = 4'b0001,
      SCAN_STEP  = 4'b0010,
      SCAN_DRAIN = 4'b0100,
      SCAN_DONE  = 4'b1000
   } scan_state_type;

   typedef enum logic [4:0] {
      SIEVE_FILL  = 5'b00001,
      SIEVE_CHECK = 5'b00010,
      SIEVE_TEST  = 5'b00100,
      SIEVE_MARK  = 5'b01000,
      SIEVE_READY = 5'b10000
   } sieve_state_type;

   typedef struct packed {
      logic ready;
      logic p_prime;
      logic q_prime;
   } lookup_type;

endpackage

[rtl/gbpf_sieve_map.sv]
// Prime bitmap over 0..LIMIT, filled by a sieve of Eratosthenes after reset.
// Offers two registered lookup ports once the sieve is done. Uses gbpf_pkg.
module gbpf_sieve_map #(
   parameter int LIMIT = 128,
   parameter int AW    = $clog2(LIMIT + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [AW-1:0]        p_addr,
   input  logic [AW-1:0]        q_addr,
   output gbpf_pkg::lookup_type lookup
);

   logic                      map_mem [0:LIMIT];
   gbpf_pkg::sieve_state_type state_ff, state_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [AW:0]               mult_ff, mult_in;
   logic [2*AW-1:0]           sq_ff, sq_in;
   logic                      rd_a_ff, rd_b_ff;
   logic                      we;
   logic [AW-1:0]             waddr;
   logic                      wdata;
   logic [AW-1:0]             addr_a;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      mult_in  = mult_ff;
      sq_in    = sq_ff;
      we       = 1'b0;
      waddr    = idx_ff;
      wdata    = 1'b0;
      addr_a   = p_addr;
      case (state_ff)
         gbpf_pkg::SIEVE_FILL: begin
            we    = 1'b1;
            waddr = idx_ff;
            wdata = (idx_ff >= AW'(2));
            if (idx_ff == AW'(LIMIT)) begin
               idx_in   = AW'(2);
               state_in = gbpf_pkg::SIEVE_CHECK;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         gbpf_pkg::SIEVE_CHECK: begin
            addr_a   = idx_ff;
            sq_in    = idx_ff * idx_ff;
            state_in = gbpf_pkg::SIEVE_TEST;
         end
         gbpf_pkg::SIEVE_TEST: begin
            if (sq_ff > (2*AW)'(LIMIT)) begin
               state_in = gbpf_pkg::SIEVE_READY;
            end else if (rd_a_ff) begin
               mult_in  = sq_ff[AW:0];
               state_in = gbpf_pkg::SIEVE_MARK;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = gbpf_pkg::SIEVE_CHECK;
            end
         end
         gbpf_pkg::SIEVE_MARK: begin
            if (mult_ff <= (AW+1)'(LIMIT)) begin
               we      = 1'b1;
               waddr   = mult_ff[AW-1:0];
               wdata   = 1'b0;
               mult_in = mult_ff + {1'b0, idx_ff};
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = gbpf_pkg::SIEVE_CHECK;
            end
         end
         gbpf_pkg::SIEVE_READY: begin
            state_in = gbpf_pkg::SIEVE_READY;
         end
         default: begin
            state_in = gbpf_pkg::SIEVE_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbpf_pkg::SIEVE_FILL;
         idx_ff   <= '0;
         mult_ff  <= '0;
         sq_ff    <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         mult_ff  <= mult_in;
         sq_ff    <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         map_mem[waddr] <= wdata;
      end
      rd_a_ff <= map_mem[addr_a];
      rd_b_ff <= map_mem[q_addr];
   end

   assign lookup.ready   = (state_ff == gbpf_pkg::SIEVE_READY);
   assign lookup.p_prime = rd_a_ff;
   assign lookup.q_prime = rd_b_ff;

endmodule

[rtl/goldbach_prime_pair_finder.sv]
// Top level of the Goldbach prime pair finder: command port and pair scan.
// Depends on gbpf_pkg and gbpf_sieve_map.
//
// Usage: after reset the block sieves a prime bitmap over 0..LIMIT and holds
// busy high meanwhile: one pass writes every entry, then each base prime up to
// the square root of LIMIT strikes its multiples, one memory write per cycle.
// A command transfers when start is high and busy is low; req_number is
// sampled then. busy stays high until the result has been shown.
// For a number above 4 the scan tests p = 2 .. number/2, one pair per cycle
// through the two bitmap read ports, then a drain state, then the result; a
// number of 4 or less answers on the next cycle. Items never overlap.
// The result is on rsp_* for one cycle with rsp_valid high; the receiver
// cannot stall it. Indices above LIMIT count as not prime.
module goldbach_prime_pair_finder #(
   parameter int LIMIT = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gbpf_pkg::NUM_W-1:0]    req_number,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [gbpf_pkg::NUM_W-1:0]    rsp_small_prime,
   output logic [gbpf_pkg::NUM_W-1:0]    rsp_large_prime,
   output logic [gbpf_pkg::COUNT_W-1:0]  rsp_pair_count
);

   localparam int AW = $clog2(LIMIT + 1);

   gbpf_pkg::scan_state_type        state_ff, state_in;
   logic [gbpf_pkg::NUM_W-1:0]      number_ff, number_in;
   logic [gbpf_pkg::NUM_W-1:0]      p_ff, p_in;
   logic [gbpf_pkg::NUM_W-1:0]      q_cur;
   logic [gbpf_pkg::NUM_W-1:0]      half;
   logic                            s1_vld_ff, s1_vld_in;
   logic                            s1_pok_ff, s1_qok_ff;
   logic [gbpf_pkg::NUM_W-1:0]      s1_p_ff, s1_q_ff;
   logic [gbpf_pkg::NUM_W-1:0]      small_ff, small_in;
   logic [gbpf_pkg::NUM_W-1:0]      large_ff, large_in;
   logic [gbpf_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                            accept;
   logic                            hit;
   gbpf_pkg::lookup_type            lookup;

   assign half   = number_ff >> 1;
   assign q_cur  = number_ff - p_ff;
   assign busy   = (state_ff != gbpf_pkg::SCAN_IDLE) || !lookup.ready;
   assign accept = start && !busy;
   assign hit    = s1_vld_ff && s1_pok_ff && s1_qok_ff && lookup.p_prime && lookup.q_prime;

   gbpf_sieve_map #(
      .LIMIT (LIMIT),
      .AW    (AW)
   ) u_map (
      .clock  (clock),
      .reset  (reset),
      .p_addr (AW'(p_ff)),
      .q_addr (AW'(q_cur)),
      .lookup (lookup)
   );

   always_comb begin
      state_in  = state_ff;
      number_in = number_ff;
      p_in      = p_ff;
      s1_vld_in = 1'b0;
      small_in  = small_ff;
      large_in  = large_ff;
      count_in  = count_ff;
      if (hit) begin
         if (count_ff == '0) begin
            small_in = s1_p_ff;
            large_in = s1_q_ff;
         end
         if (count_ff != gbpf_pkg::COUNT_MAX) begin
            count_in = count_ff + gbpf_pkg::COUNT_W'(1);
         end
      end
      case (state_ff)
         gbpf_pkg::SCAN_IDLE: begin
            if (accept) begin
               number_in = req_number;
               p_in      = gbpf_pkg::NUM_W'(2);
               small_in  = '0;
               large_in  = '0;
               count_in  = '0;
               if (req_number > gbpf_pkg::MIN_NUMBER) begin
                  state_in = gbpf_pkg::SCAN_STEP;
               end else begin
                  state_in = gbpf_pkg::SCAN_DONE;
               end
            end
         end
         gbpf_pkg::SCAN_STEP: begin
            s1_vld_in = 1'b1;
            if (p_ff == half) begin
               state_in = gbpf_pkg::SCAN_DRAIN;
            end else begin
               p_in = p_ff + gbpf_pkg::NUM_W'(1);
            end
         end
         gbpf_pkg::SCAN_DRAIN: begin
            state_in = gbpf_pkg::SCAN_DONE;
         end
         gbpf_pkg::SCAN_DONE: begin
            state_in = gbpf_pkg::SCAN_IDLE;
         end
         default: begin
            state_in = gbpf_pkg::SCAN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gbpf_pkg::SCAN_IDLE;
         p_ff      <= '0;
         s1_vld_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         p_ff      <= p_in;
         s1_vld_ff <= s1_vld_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      number_ff <= number_in;
      small_ff  <= small_in;
      large_ff  <= large_in;
      s1_p_ff   <= p_ff;
      s1_q_ff   <= q_cur;
      s1_pok_ff <= (p_ff <= LIMIT);
      s1_qok_ff <= (q_cur <= LIMIT);
   end

   assign rsp_valid       = (state_ff == gbpf_pkg::SCAN_DONE);
   assign rsp_found       = (count_ff != '0);
   assign rsp_small_prime = small_ff;
   assign rsp_large_prime = large_ff;
   assign rsp_pair_count  = count_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy low after a command transfer");

   a_pair_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
         (gbpf_pkg::NUM_W'(rsp_small_prime + rsp_large_prime) == number_ff))
      else $error("reported pair does not sum to the number");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_small_prime <= rsp_large_prime))
      else $error("reported pair out of order");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_small_prime == '0) && (rsp_large_prime == '0))
      else $error("empty result carries a pair");

endmodule
